### src/mbtcp_pkg.sv
// Shared types and constants for the Modbus TCP client framer and checker.
// Depends on nothing; imported by the top level.
`default_nettype none

package mbtcp_pkg;

  // input selector codes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_PAYLOAD = 2'd1;
  localparam logic [1:0] OP_RESP    = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_COUNT   = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER  = 3'd2;
  localparam logic [2:0] ST_BAD_RESP    = 3'd3;
  localparam logic [2:0] ST_EXCEPTION   = 3'd4;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd5;
  localparam logic [2:0] ST_UNEXPECTED  = 3'd6;

  // function codes
  localparam logic [7:0] FC_READ_COILS  = 8'h01;
  localparam logic [7:0] FC_READ_DI     = 8'h02;
  localparam logic [7:0] FC_READ_HOLD   = 8'h03;
  localparam logic [7:0] FC_READ_INPUT  = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL  = 8'h05;
  localparam logic [7:0] FC_WRITE_REG   = 8'h06;
  localparam logic [7:0] FC_WRITE_COILS = 8'h0F;
  localparam logic [7:0] FC_WRITE_REGS  = 8'h10;
  localparam logic [7:0] FC_EXC_FLAG    = 8'h80;

  // count limits
  localparam logic [15:0] LIM_BITS_RD  = 16'd2000;
  localparam logic [15:0] LIM_REGS_RD  = 16'd125;
  localparam logic [15:0] LIM_BITS_WR  = 16'd1968;
  localparam logic [15:0] LIM_REGS_WR  = 16'd123;
  localparam logic [15:0] COIL_ON      = 16'hFF00;
  localparam logic [15:0] LEN_MIN      = 16'd2;
  localparam logic [15:0] LEN_MAX      = 16'd254;

  // most results one item can cause
  localparam int RES_MAX = 13;
  localparam int RES_IW  = $clog2(RES_MAX);
  localparam int RES_CW  = $clog2(RES_MAX + 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [2:0] status;
    logic [7:0] exception_code;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

### src/modbus_tcp_client_framer_checker_top.sv
// Modbus TCP client framer and response checker, top level.
// Depends on mbtcp_pkg for codes, limits and the result type.
`default_nettype none

// Client side of a Modbus TCP transaction for function codes 1 to 6, 15 and 16.
// Each accepted request is worked in one pass into a result buffer of up to
// 13 entries, which feeds a single output register. Payload and response
// bytes sustain one item per cycle while m_tready holds; a start request fills
// the buffer with its 12 or 13 frame bytes and the next item is taken in the
// cycle the last of them moves to the output register, so a start is paced by
// the one-result-per-cycle output stage. Items that cause no result (inner header
// bytes) never block. Results are registered in the buffer, then in out_reg.
module modbus_tcp_client_framer_checker_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // function_code[7:0], unit_id[15:8], start_address[31:16],
  // quantity_or_value[47:32], data_byte[55:48]
  input  wire logic [55:0] s_tdata,
  // op[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // byte_value[7:0], status[10:8], exception_code[18:11], zero[23:19]
  output logic [23:0]      m_tdata,
  // kind[1:0]
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);
  import mbtcp_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PAYLOAD,
    PH_HEADER,
    PH_BODY
  } phase_t;

  // transaction state
  phase_t      phase, phase_next;
  logic [15:0] transaction_counter, transaction_counter_next;
  logic [7:0]  pending_function, pending_function_next;
  logic [7:0]  pending_unit, pending_unit_next;
  logic [15:0] pending_address, pending_address_next;
  logic [15:0] pending_quantity, pending_quantity_next;
  logic [7:0]  byte_position, byte_position_next;
  logic [15:0] header_shift, header_shift_next;
  logic [7:0]  body_length, body_length_next;
  logic        mismatch_flag, mismatch_flag_next;

  // result buffer and output register
  result_t            res_buf [RES_MAX];
  result_t            res_next [RES_MAX];
  logic [RES_CW-1:0]  res_n;
  logic [RES_CW-1:0]  buf_count;
  logic [RES_IW-1:0]  buf_head;
  result_t            out_reg;

  logic in_acc, move;

  // input fields
  logic [1:0]  op;
  logic [7:0]  fc_in, unit_in, b;
  logic [15:0] addr_in, q_in;

  assign op      = s_tuser;
  assign fc_in   = s_tdata[7:0];
  assign unit_in = s_tdata[15:8];
  assign addr_in = s_tdata[31:16];
  assign q_in    = s_tdata[47:32];
  assign b       = s_tdata[55:48];

  // buffer handshake
  assign move     = (buf_count != '0) && (!m_tvalid || m_tready);
  assign s_tready = (buf_count == '0) || ((buf_count == RES_CW'(1)) && move);
  assign in_acc   = s_tvalid && s_tready;

  // expected response sizes of the pending request
  logic        pend_read, pend_bits;
  logic [17:0] exp_count, exp_size;

  always_comb begin
    pend_read = (pending_function >= FC_READ_COILS) && (pending_function <= FC_READ_INPUT);
    pend_bits = (pending_function == FC_READ_COILS) || (pending_function == FC_READ_DI);
    exp_count = pend_bits ? ((18'(pending_quantity) + 18'd7) >> 3)
                          : (18'(pending_quantity) << 1);
    exp_size  = pend_read ? (exp_count + 18'd2) : 18'd5;
  end

  // single-pass item step
  logic        fc_ok, lim_chk, multi;
  logic [15:0] limit, q_enc, len, tid;
  logic [16:0] bc_wide;
  logic [7:0]  bc;
  logic [15:0] hs_shift;
  logic        mm, fin;
  result_t     st_res;

  always_comb begin
    phase_next               = phase;
    transaction_counter_next = transaction_counter;
    pending_function_next    = pending_function;
    pending_unit_next        = pending_unit;
    pending_address_next     = pending_address;
    pending_quantity_next    = pending_quantity;
    byte_position_next       = byte_position;
    header_shift_next        = header_shift;
    body_length_next         = body_length;
    mismatch_flag_next       = mismatch_flag;
    for (int i = 0; i < RES_MAX; i++) begin
      res_next[i] = '0;
    end
    res_n    = '0;
    fc_ok    = 1'b1;
    lim_chk  = 1'b1;
    limit    = '0;
    multi    = (fc_in == FC_WRITE_COILS) || (fc_in == FC_WRITE_REGS);
    q_enc    = q_in;
    bc_wide  = '0;
    bc       = '0;
    len      = '0;
    tid      = transaction_counter + 16'd1;
    hs_shift = {header_shift[7:0], b};
    mm       = mismatch_flag;
    fin      = 1'b0;
    st_res   = '0;
    st_res.kind = KIND_STATUS;

    unique case (op)
      OP_START: begin
        unique case (fc_in) inside
          FC_READ_COILS, FC_READ_DI:    limit = LIM_BITS_RD;
          FC_READ_HOLD, FC_READ_INPUT:  limit = LIM_REGS_RD;
          FC_WRITE_COIL, FC_WRITE_REG:  lim_chk = 1'b0;
          FC_WRITE_COILS:               limit = LIM_BITS_WR;
          FC_WRITE_REGS:                limit = LIM_REGS_WR;
          default:                      fc_ok = 1'b0;
        endcase
        if (fc_in == FC_WRITE_COIL) begin
          q_enc = (q_in != '0) ? COIL_ON : '0;
        end
        bc_wide = (fc_in == FC_WRITE_COILS) ? ((17'(q_in) + 17'd7) >> 3)
                                            : (17'(q_in) << 1);
        bc      = bc_wide[7:0];
        len     = multi ? (16'(bc) + 16'd7) : 16'd6;
        if (!fc_ok || (lim_chk && ((q_in == '0) || (q_in > limit)))) begin
          phase_next         = PH_IDLE;
          mismatch_flag_next = 1'b0;
          st_res.status      = fc_ok ? ST_BAD_COUNT : ST_UNSUPPORTED;
          res_next[0]        = st_res;
          res_n              = RES_CW'(1);
        end else begin
          transaction_counter_next = tid;
          pending_function_next    = fc_in;
          pending_unit_next        = unit_in;
          pending_address_next     = addr_in;
          pending_quantity_next    = q_enc;
          header_shift_next        = '0;
          mismatch_flag_next       = 1'b0;
          body_length_next         = '0;
          res_next[0].byte_value   = tid[15:8];
          res_next[1].byte_value   = tid[7:0];
          res_next[4].byte_value   = len[15:8];
          res_next[5].byte_value   = len[7:0];
          res_next[6].byte_value   = unit_in;
          res_next[7].byte_value   = fc_in;
          res_next[8].byte_value   = addr_in[15:8];
          res_next[9].byte_value   = addr_in[7:0];
          res_next[10].byte_value  = q_enc[15:8];
          res_next[11].byte_value  = q_enc[7:0];
          res_next[12].byte_value  = bc;
          if (multi) begin
            res_n              = RES_CW'(RES_MAX);
            phase_next         = PH_PAYLOAD;
            byte_position_next = bc;
          end else begin
            res_n              = RES_CW'(RES_MAX - 1);
            phase_next         = PH_HEADER;
            byte_position_next = '0;
          end
        end
      end
      OP_PAYLOAD: begin
        res_n = RES_CW'(1);
        if (phase != PH_PAYLOAD) begin
          st_res.status = ST_UNEXPECTED;
          res_next[0]   = st_res;
        end else begin
          res_next[0].kind       = KIND_FRAME;
          res_next[0].byte_value = b;
          byte_position_next     = byte_position - 8'd1;
          if (byte_position == 8'd1) begin
            phase_next = PH_HEADER;
          end
        end
      end
      OP_RESP: begin
        if (phase == PH_HEADER) begin
          header_shift_next = hs_shift;
          if (byte_position == 8'd1 && hs_shift != transaction_counter) mm = 1'b1;
          if (byte_position == 8'd3 && hs_shift != '0) mm = 1'b1;
          if (byte_position == 8'd5) begin
            if (hs_shift < LEN_MIN || hs_shift > LEN_MAX) begin
              mm               = 1'b1;
              body_length_next = '0;
            end else begin
              body_length_next = hs_shift[7:0] - 8'd1;
            end
          end
          mismatch_flag_next = mm;
          if (byte_position < 8'd6) begin
            byte_position_next = byte_position + 8'd1;
          end else begin
            if (b != pending_unit) mm = 1'b1;
            byte_position_next = '0;
            if (mm) begin
              phase_next         = PH_IDLE;
              mismatch_flag_next = 1'b0;
              st_res.status      = ST_BAD_HEADER;
              res_next[0]        = st_res;
              res_n              = RES_CW'(1);
            end else begin
              phase_next         = PH_BODY;
              header_shift_next  = '0;
              mismatch_flag_next = (18'(body_length) != exp_size);
            end
          end
        end else if (phase == PH_BODY) begin
          header_shift_next = hs_shift;
          if (byte_position == 8'd0 && b != pending_function) mm = 1'b1;
          if (pend_read) begin
            if (byte_position == 8'd1 && 18'(b) != exp_count) mm = 1'b1;
          end else begin
            if (byte_position == 8'd2 && hs_shift != pending_address) mm = 1'b1;
            if (byte_position == 8'd4 && hs_shift != pending_quantity) mm = 1'b1;
          end
          fin = ({1'b0, byte_position} + 9'd1) >= {1'b0, body_length};
          if (body_length == 8'd2 &&
              header_shift[7:0] == (pending_function | FC_EXC_FLAG)) begin
            st_res.status         = ST_EXCEPTION;
            st_res.exception_code = b;
          end else begin
            st_res.status = mm ? ST_BAD_RESP : ST_OK;
          end
          // streamed read data, then the closing status
          if (pend_read && byte_position >= 8'd2) begin
            res_next[0].kind       = KIND_DATA;
            res_next[0].byte_value = b;
            res_n                  = RES_CW'(1);
            if (fin) begin
              res_next[1] = st_res;
              res_n       = RES_CW'(2);
            end
          end else if (fin) begin
            res_next[0] = st_res;
            res_n       = RES_CW'(1);
          end
          if (fin) begin
            phase_next         = PH_IDLE;
            mismatch_flag_next = 1'b0;
            byte_position_next = '0;
          end else begin
            mismatch_flag_next = mm;
            byte_position_next = byte_position + 8'd1;
          end
        end else begin
          st_res.status = ST_UNEXPECTED;
          res_next[0]   = st_res;
          res_n         = RES_CW'(1);
        end
      end
      default: begin
        res_n = '0;
      end
    endcase

    // mark the final result of this item
    for (int i = 0; i < RES_MAX; i++) begin
      res_next[i].last = (RES_CW'(i) == (res_n - RES_CW'(1))) && (res_n != '0);
    end
  end

  // state, buffer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_IDLE;
      transaction_counter <= '0;
      pending_function    <= '0;
      pending_unit        <= '0;
      pending_address     <= '0;
      pending_quantity    <= '0;
      byte_position       <= '0;
      header_shift        <= '0;
      body_length         <= '0;
      mismatch_flag       <= 1'b0;
      buf_count           <= '0;
      buf_head            <= '0;
      m_tvalid            <= 1'b0;
    end else begin
      if (move) begin
        out_reg  <= res_buf[buf_head];
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // a new request replaces the buffer as its last result moves out
      if (in_acc) begin
        phase               <= phase_next;
        transaction_counter <= transaction_counter_next;
        pending_function    <= pending_function_next;
        pending_unit        <= pending_unit_next;
        pending_address     <= pending_address_next;
        pending_quantity    <= pending_quantity_next;
        byte_position       <= byte_position_next;
        header_shift        <= header_shift_next;
        body_length         <= body_length_next;
        mismatch_flag       <= mismatch_flag_next;
        for (int i = 0; i < RES_MAX; i++) begin
          res_buf[i] <= res_next[i];
        end
        buf_head  <= '0;
        buf_count <= res_n;
      end else if (move) begin
        buf_head  <= buf_head + RES_IW'(1);
        buf_count <= buf_count - RES_CW'(1);
      end
    end
  end

  assign m_tdata = {5'd0, out_reg.exception_code, out_reg.status, out_reg.byte_value};
  assign m_tuser = out_reg.kind;
  assign m_tlast = out_reg.last;

`ifndef SYNTH
  // a request is only taken once the buffer drains
  a_accept_drains: assert property (@(posedge clk) disable iff (rst)
    (in_acc && buf_count != '0) |-> move)
    else $error("request accepted while buffer still holds results");

  // buffer never reads past its end
  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(buf_head) + 32'(buf_count)) <= RES_MAX)
    else $error("result buffer overrun");

  // a good start request loads a full frame
  a_frame_len: assert property (@(posedge clk) disable iff (rst)
    (in_acc && op == OP_START && phase_next != PH_IDLE) |=>
      (buf_count == RES_CW'(RES_MAX) || buf_count == RES_CW'(RES_MAX - 1)))
    else $error("start request frame length wrong");

  // a result taken from the buffer always reaches the output
  a_move_valid: assert property (@(posedge clk) disable iff (rst)
    move |=> m_tvalid)
    else $error("buffered result lost");
`endif

endmodule

`default_nettype wire
